@@ design/salru_pkg.sv @@
// Package for the set-associative LRU cache model.
// Holds the item types, operation and register codes, state encoding and defaults.
// No dependencies.
package salru_pkg;

	localparam int DEF_MAX_SETS  = 256;
	localparam int DEF_MAX_WAYS  = 8;
	localparam int DEF_ADDR_BITS = 32;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 4;
	localparam int FLUSH_CNT_W = 13;

	typedef enum logic [1:0] {
		OP_DREAD  = 2'd0,
		OP_DWRITE = 2'd1,
		OP_IFETCH = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPLIT     = 3'd0,
		CFG_WB        = 3'd1,
		CFG_WALLOC    = 3'd2,
		CFG_BLOCK     = 3'd3,
		CFG_WAYS      = 3'd4,
		CFG_INST_SETS = 3'd5,
		CFG_DATA_SETS = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_FL_RD,
		ST_FL_ACC,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic                   hit;
		logic                   fetched;
		logic                   replaced;
		logic                   copied_back;
		logic [FLUSH_CNT_W-1:0] flush_dirty_count;
		logic [31:0]            inst_access_total;
		logic [31:0]            inst_miss_total;
		logic [31:0]            data_access_total;
		logic [31:0]            data_miss_total;
	} rsp_t;

	typedef struct packed {
		logic hit;
		logic fetched;
		logic replaced;
		logic copied_back;
	} flags_t;

endpackage

@@ design/set_assoc_lru_cache_model.sv @@
// Set-associative cache model with true LRU replacement, top level.
// Access: registered set row read, then update and write back once the output is free.
// Flush (write-back only): read, then count, each data set and, if split, each inst set.
// One item is in work at a time; a finished item waits in the output register.
// After reset a clearing pass zeroes all 2*MAX_SETS set rows before items are taken.
module set_assoc_lru_cache_model #(
	parameter int MAX_SETS  = salru_pkg::DEF_MAX_SETS,
	parameter int MAX_WAYS  = salru_pkg::DEF_MAX_WAYS,
	parameter int ADDR_BITS = salru_pkg::DEF_ADDR_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  salru_pkg::req_t                     req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output salru_pkg::rsp_t                     rsp
);
	import salru_pkg::*;

	localparam int AW       = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int TAG_W    = AW - 2;
	localparam int LOG_SETS = $clog2(MAX_SETS + 1) - 1;
	localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
	localparam int ROWS     = 2 * MAX_SETS;
	localparam int ROW_W    = $clog2(ROWS);
	localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int FILL_W   = $clog2(MAX_WAYS + 1);
	localparam logic [31:0] AMASK =
		(ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

	// Configuration registers.
	logic       split_q, wb_q, walloc_q;
	logic [3:0] block_q, ways_q, isb_q, dsb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b0;
			wb_q <= 1'b1;
			walloc_q <= 1'b1;
			block_q <= 4'd4;
			ways_q <= 4'd1;
			isb_q <= 4'd6;
			dsb_q <= 4'd6;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPLIT:     split_q <= cfg_data[0];
				CFG_WB:        wb_q <= cfg_data[0];
				CFG_WALLOC:    walloc_q <= cfg_data[0];
				CFG_BLOCK:     block_q <= cfg_data;
				CFG_WAYS:      ways_q <= cfg_data;
				CFG_INST_SETS: isb_q <= cfg_data;
				CFG_DATA_SETS: dsb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [3:0]        bb_e, isb_e, dsb_e;
	logic [FILL_W-1:0] ways_e;

	always_comb begin
		bb_e = (block_q < 4'd2) ? 4'd2 : ((block_q > 4'd12) ? 4'd12 : block_q);
		ways_e = (ways_q == 4'd0) ? FILL_W'(1)
			: (({1'b0, ways_q} > 5'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : FILL_W'(ways_q));
		isb_e = (isb_q < 4'(LOG_SETS)) ? isb_q : 4'(LOG_SETS);
		dsb_e = (dsb_q < 4'(LOG_SETS)) ? dsb_q : 4'(LOG_SETS);
	end

	// Set rows: tags, dirty bits, recency ranks and fill count share one address.
	logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem  [ROWS];
	logic [MAX_WAYS-1:0]             dirty_mem[ROWS];
	logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem [ROWS];
	logic [FILL_W-1:0]               fill_mem [ROWS];

	logic [MAX_WAYS-1:0][TAG_W-1:0]  rd_tags_s1, wr_tags;
	logic [MAX_WAYS-1:0]             rd_dirty_s1, wr_dirty;
	logic [MAX_WAYS-1:0][RANK_W-1:0] rd_ranks_s1, wr_ranks;
	logic [FILL_W-1:0]               rd_fill_s1, wr_fill;
	logic                            rd_en, wr_en;
	logic [ROW_W-1:0]                rd_addr, wr_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_addr] <= wr_tags;
			dirty_mem[wr_addr] <= wr_dirty;
			rank_mem[wr_addr] <= wr_ranks;
			fill_mem[wr_addr] <= wr_fill;
		end
		if (rd_en) begin
			rd_tags_s1 <= tag_mem[rd_addr];
			rd_dirty_s1 <= dirty_mem[rd_addr];
			rd_ranks_s1 <= rank_mem[rd_addr];
			rd_fill_s1 <= fill_mem[rd_addr];
		end
	end

	// Address split of an incoming item.
	logic [31:0]      addr_m;
	logic             part_in;
	logic [3:0]       sb_in;
	logic [SET_W-1:0] set_in;
	logic [4:0]       tag_sh;
	logic [ROW_W-1:0] row_in;
	logic [TAG_W-1:0] tag_in;

	always_comb begin
		addr_m = req.address & AMASK;
		part_in = !(split_q && op_t'(req.operation) == OP_IFETCH);
		sb_in = part_in ? dsb_e : isb_e;
		set_in = SET_W'(addr_m >> bb_e) & SET_W'((32'd1 << sb_in) - 32'd1);
		tag_sh = {1'b0, bb_e} + {1'b0, sb_in};
		tag_in = TAG_W'(addr_m >> tag_sh);
		row_in = part_in ? ROW_W'(MAX_SETS) + ROW_W'(set_in) : ROW_W'(set_in);
	end

	// Item in work.
	op_t              op_q;
	logic [ROW_W-1:0] row_q;
	logic [TAG_W-1:0] tag_q;
	logic [ROW_W-1:0] clr_q;
	logic [SET_W-1:0] fidx_q;
	logic             fpart_q;
	logic [FLUSH_CNT_W-1:0] fcnt_q;
	logic [31:0] ia_q, im_q, da_q, dm_q;

	state_t state_q, state_d;

	logic                            accept, out_free, clr_last, fl_last;
	logic [MAX_WAYS-1:0][TAG_W-1:0]  upd_tags;
	logic [MAX_WAYS-1:0]             upd_dirty;
	logic [MAX_WAYS-1:0][RANK_W-1:0] upd_ranks;
	logic [FILL_W-1:0]               upd_fill;
	flags_t                          upd_flags;
	logic [SET_W-1:0]                fl_mask;
	logic [ROW_W-1:0]                fl_row;
	logic [FILL_W-1:0]               fl_n;
	logic [FLUSH_CNT_W-1:0]          fl_add;

	salru_set_logic #(
		.MAX_WAYS (MAX_WAYS),
		.TAG_W    (TAG_W),
		.RANK_W   (RANK_W),
		.FILL_W   (FILL_W)
	) u_set (
		.tags           (rd_tags_s1),
		.dirty          (rd_dirty_s1),
		.ranks          (rd_ranks_s1),
		.fill           (rd_fill_s1),
		.tag            (tag_q),
		.ways           (ways_e),
		.is_write       (op_q == OP_DWRITE),
		.write_back     (wb_q),
		.write_allocate (walloc_q),
		.tags_new       (upd_tags),
		.dirty_new      (upd_dirty),
		.ranks_new      (upd_ranks),
		.fill_new       (upd_fill),
		.flags          (upd_flags)
	);

	always_comb begin
		out_free = !rsp_valid || rsp_ready;
		accept = req_valid && req_ready;
		clr_last = clr_q == ROW_W'(ROWS - 1);
		fl_mask = SET_W'((32'd1 << (fpart_q ? dsb_e : isb_e)) - 32'd1);
		fl_last = fidx_q == fl_mask;
		fl_row = fpart_q ? ROW_W'(MAX_SETS) + ROW_W'(fidx_q) : ROW_W'(fidx_q);
		// Flush counts every filled way, regardless of the ways in use.
		fl_n = (rd_fill_s1 > FILL_W'(MAX_WAYS)) ? FILL_W'(MAX_WAYS) : rd_fill_s1;
		fl_add = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if ((FILL_W'(i) < fl_n) && rd_dirty_s1[i])
				fl_add = fl_add + FLUSH_CNT_W'(1);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(req.operation) != OP_FLUSH)
						state_d = ST_UPD;
					else
						state_d = wb_q ? ST_FL_RD : ST_RESP;
				end
			end
			ST_UPD: if (out_free) state_d = ST_IDLE;
			ST_FL_RD: state_d = ST_FL_ACC;
			ST_FL_ACC: state_d = (fl_last && !(fpart_q && split_q)) ? ST_RESP : ST_FL_RD;
			ST_RESP: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		req_ready = 1'b0;
		rd_en = 1'b0;
		rd_addr = row_in;
		wr_en = 1'b0;
		wr_addr = row_q;
		wr_tags = upd_tags;
		wr_dirty = upd_dirty;
		wr_ranks = upd_ranks;
		wr_fill = upd_fill;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_q;
				wr_tags = '0;
				wr_dirty = '0;
				wr_ranks = '0;
				wr_fill = '0;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				rd_en = req_valid;
			end
			ST_UPD: wr_en = out_free;
			ST_FL_RD: begin
				rd_en = 1'b1;
				rd_addr = fl_row;
			end
			ST_FL_ACC, ST_RESP: ;
			default: ;
		endcase
	end

	logic miss_upd;
	assign miss_upd = !upd_flags.hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			ia_q <= '0;
			im_q <= '0;
			da_q <= '0;
			dm_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + ROW_W'(1);
			if ((state_q == ST_UPD || state_q == ST_RESP) && out_free)
				rsp_valid <= 1'b1;
			else if (rsp_ready)
				rsp_valid <= 1'b0;
			if (state_q == ST_UPD && out_free) begin
				if (op_q == OP_IFETCH) begin
					if (ia_q != '1) ia_q <= ia_q + 32'd1;
					if (miss_upd && im_q != '1) im_q <= im_q + 32'd1;
				end else begin
					if (da_q != '1) da_q <= da_q + 32'd1;
					if (miss_upd && dm_q != '1) dm_q <= dm_q + 32'd1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(req.operation);
			row_q <= row_in;
			tag_q <= tag_in;
			fidx_q <= '0;
			fpart_q <= 1'b1;
			fcnt_q <= '0;
		end
		if (state_q == ST_FL_ACC) begin
			fcnt_q <= fcnt_q + fl_add;
			fidx_q <= fl_last ? '0 : fidx_q + SET_W'(1);
			if (fl_last)
				fpart_q <= 1'b0;
		end
		if (state_q == ST_UPD && out_free) begin
			rsp.hit <= upd_flags.hit;
			rsp.fetched <= upd_flags.fetched;
			rsp.replaced <= upd_flags.replaced;
			rsp.copied_back <= upd_flags.copied_back;
			rsp.flush_dirty_count <= '0;
			if (op_q == OP_IFETCH) begin
				rsp.inst_access_total <= (ia_q != '1) ? ia_q + 32'd1 : ia_q;
				rsp.inst_miss_total <= (miss_upd && im_q != '1) ? im_q + 32'd1 : im_q;
				rsp.data_access_total <= da_q;
				rsp.data_miss_total <= dm_q;
			end else begin
				rsp.inst_access_total <= ia_q;
				rsp.inst_miss_total <= im_q;
				rsp.data_access_total <= (da_q != '1) ? da_q + 32'd1 : da_q;
				rsp.data_miss_total <= (miss_upd && dm_q != '1) ? dm_q + 32'd1 : dm_q;
			end
		end
		if (state_q == ST_RESP && out_free) begin
			rsp.hit <= 1'b0;
			rsp.fetched <= 1'b0;
			rsp.replaced <= 1'b0;
			rsp.copied_back <= 1'b0;
			rsp.flush_dirty_count <= fcnt_q;
			rsp.inst_access_total <= ia_q;
			rsp.inst_miss_total <= im_q;
			rsp.data_access_total <= da_q;
			rsp.data_miss_total <= dm_q;
		end
	end

endmodule

@@ design/salru_set_logic.sv @@
// Lookup and LRU update of one cache set row.
// Searches the ways, picks a victim and builds the row to write back.
// Depends on salru_pkg.
module salru_set_logic #(
	parameter int MAX_WAYS = salru_pkg::DEF_MAX_WAYS,
	parameter int TAG_W    = 30,
	parameter int RANK_W   = 3,
	parameter int FILL_W   = 4
) (
	input  logic [MAX_WAYS-1:0][TAG_W-1:0]  tags,
	input  logic [MAX_WAYS-1:0]             dirty,
	input  logic [MAX_WAYS-1:0][RANK_W-1:0] ranks,
	input  logic [FILL_W-1:0]               fill,
	input  logic [TAG_W-1:0]                tag,
	input  logic [FILL_W-1:0]               ways,
	input  logic                            is_write,
	input  logic                            write_back,
	input  logic                            write_allocate,
	output logic [MAX_WAYS-1:0][TAG_W-1:0]  tags_new,
	output logic [MAX_WAYS-1:0]             dirty_new,
	output logic [MAX_WAYS-1:0][RANK_W-1:0] ranks_new,
	output logic [FILL_W-1:0]               fill_new,
	output salru_pkg::flags_t               flags
);
	import salru_pkg::*;

	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [RANK_W:0] NO_RANK = '1;
	localparam logic [RANK_W-1:0] RANK_CAP = RANK_W'(MAX_WAYS - 1);

	logic [FILL_W-1:0] n;
	logic              hit;
	logic [WAY_W-1:0]  hw;
	logic [WAY_W-1:0]  victim;
	logic [WAY_W-1:0]  w;
	logic [RANK_W:0]   old;
	logic              around;
	logic              grow;

	always_comb begin
		n = (fill > ways) ? ways : fill;
		hit = 1'b0;
		hw = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (!hit && (FILL_W'(i) < n) && tags[i] == tag) begin
				hit = 1'b1;
				hw = WAY_W'(i);
			end
		end
		// Largest rank wins; strict compare keeps the lowest way on a tie.
		victim = '0;
		for (int i = 1; i < MAX_WAYS; i++) begin
			if ((FILL_W'(i) < n) && ranks[i] > ranks[victim])
				victim = WAY_W'(i);
		end
	end

	always_comb begin
		around = !hit && is_write && !write_allocate;
		grow = !hit && (n < ways);
		w = hit ? hw : (grow ? WAY_W'(n) : victim);
		old = grow ? NO_RANK : {1'b0, ranks[w]};

		flags = '0;
		flags.hit = hit;
		tags_new = tags;
		dirty_new = dirty;
		ranks_new = ranks;
		fill_new = fill;

		if (around) begin
			flags.copied_back = 1'b1;
		end else begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if ((FILL_W'(i) < n) && WAY_W'(i) != w && {1'b0, ranks[i]} < old
					&& ranks[i] < RANK_CAP)
					ranks_new[i] = ranks[i] + RANK_W'(1);
			end
			ranks_new[w] = '0;
			if (hit) begin
				if (is_write) begin
					dirty_new[w] = 1'b1;
					flags.copied_back = !write_back;
				end
			end else begin
				flags.fetched = 1'b1;
				if (grow) begin
					fill_new = n + FILL_W'(1);
				end else begin
					flags.replaced = 1'b1;
					flags.copied_back = write_back && dirty[w];
				end
				tags_new[w] = tag;
				dirty_new[w] = is_write;
				if (is_write && !write_back)
					flags.copied_back = 1'b1;
			end
		end
	end

endmodule

@@ design/salru_checker.sv @@
// Port-level checks for the set-associative LRU cache model.
// Depends on salru_pkg; bound to set_assoc_lru_cache_model.
module salru_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     rsp_valid,
	input logic                     rsp_ready,
	input salru_pkg::rsp_t          rsp
);
	import salru_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("item changed while stalled");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.hit |-> !rsp.fetched && !rsp.replaced)
		else $error("hit reported together with a fill");

	a_repl_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.replaced |-> rsp.fetched)
		else $error("eviction without fetch");

	a_miss_le_acc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.inst_miss_total <= rsp.inst_access_total
			&& rsp.data_miss_total <= rsp.data_access_total)
		else $error("miss count exceeds access count");

endmodule

bind set_assoc_lru_cache_model salru_checker u_salru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

@@ sim/tb_set_assoc_lru_cache_model.sv @@
// Testbench for the set-associative LRU cache model.
// It checks every response against a built-in predictor and uses random idling on both channels.
// Depends on salru_pkg and set_assoc_lru_cache_model.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model;
	import salru_pkg::*;

	localparam int SETS = 256;
	localparam int WAYS = 8;
	localparam int NO_RANK = 255;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	req_t req;
	rsp_t rsp;

	set_assoc_lru_cache_model dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// Predictor state.
	logic [31:0] tag_mem [0:2*SETS*WAYS-1];
	bit dirty_mem [0:2*SETS*WAYS-1];
	int rank_mem [0:2*SETS*WAYS-1];
	int fill_mem [0:2*SETS-1];
	logic [31:0] inst_acc, inst_mis, data_acc, data_mis;
	logic [3:0] reg_file [0:6];

	rsp_t expected_rsps [$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 1;
	endfunction

	function automatic int eff_bits(logic [3:0] r);
		return (r > 8) ? 8 : r;
	endfunction

	function automatic void touch_line(int base, int n, int w, int old);
		for (int i = 0; i < n; i++) begin
			if (i != w && rank_mem[base+i] < old && rank_mem[base+i] < WAYS - 1)
				rank_mem[base+i]++;
		end
		rank_mem[base+w] = 0;
	endfunction

	// Returns 1 on a miss.
	function automatic bit lookup(int part, int sbits, logic [31:0] addr, bit is_wr,
			inout flags_t fl);
		int bb, ways, set_no, sidx, base, n, w, best;
		logic [31:0] tag;
		bb = (reg_file[CFG_BLOCK] < 2) ? 2 : (reg_file[CFG_BLOCK] > 12) ? 12 :
			reg_file[CFG_BLOCK];
		ways = (reg_file[CFG_WAYS] == 0) ? 1 : (reg_file[CFG_WAYS] > WAYS) ? WAYS :
			reg_file[CFG_WAYS];
		set_no = (addr >> bb) & ((1 << sbits) - 1);
		tag = addr >> (bb + sbits);
		sidx = part * SETS + set_no;
		base = sidx * WAYS;
		n = fill_mem[sidx];
		if (n > ways) n = ways;
		for (int i = 0; i < n; i++) begin
			if (tag_mem[base+i] == tag) begin
				fl.hit = 1;
				touch_line(base, n, i, rank_mem[base+i]);
				if (is_wr) begin
					dirty_mem[base+i] = 1;
					if (!reg_file[CFG_WB][0]) fl.copied_back = 1;
				end
				return 0;
			end
		end
		if (is_wr && !reg_file[CFG_WALLOC][0]) begin
			fl.copied_back = 1;
			return 1;
		end
		fl.fetched = 1;
		if (n < ways) begin
			w = n;
			touch_line(base, n, w, NO_RANK);
			fill_mem[sidx] = n + 1;
		end else begin
			best = 0;
			for (int i = 1; i < n; i++)
				if (rank_mem[base+i] > rank_mem[base+best]) best = i;
			w = best;
			fl.replaced = 1;
			if (reg_file[CFG_WB][0] && dirty_mem[base+w]) fl.copied_back = 1;
			touch_line(base, n, w, rank_mem[base+w]);
		end
		tag_mem[base+w] = tag;
		dirty_mem[base+w] = is_wr;
		if (is_wr && !reg_file[CFG_WB][0]) fl.copied_back = 1;
		return 1;
	endfunction

	function automatic int dirty_lines(int part, int sbits);
		int cnt = 0;
		for (int s = 0; s < (1 << sbits); s++)
			for (int w = 0; w < fill_mem[part*SETS+s]; w++)
				if (dirty_mem[(part*SETS+s)*WAYS+w]) cnt++;
		return cnt;
	endfunction

	function automatic rsp_t predict_cache(req_t r);
		rsp_t res;
		flags_t fl;
		int cnt, dsb;
		fl = '0;
		cnt = 0;
		dsb = eff_bits(reg_file[CFG_DATA_SETS]);
		case (op_t'(r.operation))
			OP_FLUSH: begin
				if (reg_file[CFG_WB][0]) begin
					cnt = dirty_lines(1, dsb);
					if (reg_file[CFG_SPLIT][0])
						cnt += dirty_lines(0, eff_bits(reg_file[CFG_INST_SETS]));
				end
			end
			OP_IFETCH: begin
				inst_acc = sat_inc(inst_acc);
				if (reg_file[CFG_SPLIT][0] ?
						lookup(0, eff_bits(reg_file[CFG_INST_SETS]), r.address, 0, fl) :
						lookup(1, dsb, r.address, 0, fl))
					inst_mis = sat_inc(inst_mis);
			end
			default: begin
				data_acc = sat_inc(data_acc);
				if (lookup(1, dsb, r.address, r.operation == OP_DWRITE, fl))
					data_mis = sat_inc(data_mis);
			end
		endcase
		res.hit = fl.hit;
		res.fetched = fl.fetched;
		res.replaced = fl.replaced;
		res.copied_back = fl.copied_back;
		res.flush_dirty_count = cnt[FLUSH_CNT_W-1:0];
		res.inst_access_total = inst_acc;
		res.inst_miss_total = inst_mis;
		res.data_access_total = data_acc;
		res.data_miss_total = data_mis;
		return res;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	always @(negedge clk) rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				$display("%0t: response with none expected, actual %0h", $time, rsp);
			end else begin
				e = expected_rsps.pop_front();
				check_field("hit", 32'(e.hit), 32'(rsp.hit));
				check_field("fetched", 32'(e.fetched), 32'(rsp.fetched));
				check_field("replaced", 32'(e.replaced), 32'(rsp.replaced));
				check_field("copied_back", 32'(e.copied_back), 32'(rsp.copied_back));
				check_field("flush_dirty_count", 32'(e.flush_dirty_count),
					32'(rsp.flush_dirty_count));
				check_field("inst_access_total", e.inst_access_total, rsp.inst_access_total);
				check_field("inst_miss_total", e.inst_miss_total, rsp.inst_miss_total);
				check_field("data_access_total", e.data_access_total, rsp.data_access_total);
				check_field("data_miss_total", e.data_miss_total, rsp.data_miss_total);
			end
		end
	end

	// Called at a falling edge; returns at a falling edge.
	task automatic send_item(op_t op, logic [31:0] addr);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 0;
			@(negedge clk);
		end
		req_valid = 1;
		req.operation = op;
		req.address = addr;
		do @(posedge clk); while (!req_ready);
		expected_rsps.push_back(predict_cache(req));
		@(negedge clk);
		req_valid = 0;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [3:0] val);
		wait (expected_rsps.size() == 0);
		repeat (4) @(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		reg_file[idx] = val;
		@(negedge clk);
		cfg_we = 0;
	endtask

	task automatic test_replacement;
		write_reg(CFG_WAYS, 4'd2);
		write_reg(CFG_DATA_SETS, 4'd0);
		send_item(OP_DREAD, 32'h0000_1000);
		send_item(OP_DREAD, 32'h0000_1004);
		send_item(OP_DWRITE, 32'h0000_2000);
		send_item(OP_DREAD, 32'h0000_3000);
		send_item(OP_DREAD, 32'h0000_2008);
		send_item(OP_DWRITE, 32'h0000_4000);
		send_item(OP_FLUSH, 32'hFFFF_FFFF);
		send_item(OP_IFETCH, 32'hFFFF_FFFF);
		send_item(OP_IFETCH, 32'h0000_0000);
	endtask

	task automatic test_write_policies;
		write_reg(CFG_WALLOC, 4'd0);
		send_item(OP_DWRITE, 32'h0000_9000);
		write_reg(CFG_WB, 4'd0);
		send_item(OP_DWRITE, 32'h0000_0004);
		send_item(OP_DWRITE, 32'h0000_A000);
		write_reg(CFG_WALLOC, 4'd1);
		send_item(OP_DWRITE, 32'h0000_B000);
		send_item(OP_FLUSH, 32'h0);
	endtask

	// Fill eight ways, then shrink the associativity; also split mode and out-of-range values.
	task automatic test_geometry;
		write_reg(CFG_WB, 4'd1);
		write_reg(CFG_WAYS, 4'd8);
		for (int i = 0; i < 8; i++) send_item(OP_DWRITE, 32'(i) << 12);
		write_reg(CFG_WAYS, 4'd15);
		write_reg(CFG_WAYS, 4'd2);
		send_item(OP_DREAD, 32'h0000_7000);
		send_item(OP_DREAD, 32'h0000_9000);
		write_reg(CFG_SPLIT, 4'd1);
		write_reg(CFG_INST_SETS, 4'd15);
		write_reg(CFG_BLOCK, 4'd0);
		send_item(OP_IFETCH, 32'h8000_0000);
		send_item(OP_FLUSH, 32'h0);
		write_reg(CFG_BLOCK, 4'd15);
		send_item(OP_IFETCH, 32'h7FFF_FFFF);
	endtask

	task automatic test_random(int items);
		logic [31:0] addr;
		int r;
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_SPLIT, 4'($urandom_range(1)));
			write_reg(CFG_WB, 4'($urandom_range(1)));
			write_reg(CFG_WALLOC, 4'($urandom_range(1)));
			write_reg(CFG_BLOCK, 4'((ph == 0) ? 2 : (ph == 7) ? 12 : $urandom_range(15)));
			write_reg(CFG_WAYS, 4'((ph == 0) ? 1 : (ph == 7) ? 8 : $urandom_range(15)));
			write_reg(CFG_INST_SETS, 4'((ph == 7) ? 8 : $urandom_range(3)));
			write_reg(CFG_DATA_SETS, 4'((ph == 0) ? 0 : (ph == 7) ? 8 : $urandom_range(4)));
			for (int i = 0; i < items / 8; i++) begin
				r = $urandom_range(99);
				if ($urandom_range(9) == 0)
					addr = $urandom;
				else
					addr = ($urandom_range(11) << (reg_file[CFG_BLOCK] + 4)) |
						($urandom & 32'h0000_0FFF);
				send_item((r < 4) ? OP_FLUSH : (r < 30) ? OP_IFETCH :
					(r < 65) ? OP_DREAD : OP_DWRITE, addr);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 2*SETS*WAYS; i++) begin
			tag_mem[i] = '0;
			dirty_mem[i] = 0;
			rank_mem[i] = 0;
		end
		for (int i = 0; i < 2*SETS; i++) fill_mem[i] = 0;
		inst_acc = 0; inst_mis = 0; data_acc = 0; data_mis = 0;
		reg_file[CFG_SPLIT] = 0; reg_file[CFG_WB] = 1; reg_file[CFG_WALLOC] = 1;
		reg_file[CFG_BLOCK] = 4; reg_file[CFG_WAYS] = 1;
		reg_file[CFG_INST_SETS] = 6; reg_file[CFG_DATA_SETS] = 6;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		req_valid = 0; req = '0;
		rsp_ready = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_replacement();
		test_write_policies();
		test_geometry();
		send_idle_pct = 21; recv_idle_pct = 70;
		test_random(200);
		send_idle_pct = 70; recv_idle_pct = 21;
		test_random(200);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(200);

		wait (expected_rsps.size() == 0);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
